// File: hdl/gda_pkg.sv
package gda_pkg;

    localparam int FIRST_YEAR = 1900;
    localparam int LAST_YEAR  = 2030;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 17;
    localparam int CMD_W   = 3;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;
    localparam int RES_YEAR_W = 11;
    localparam int VALUE_W    = 16;

    // days from FIRST_YEAR-01-01 to (LAST_YEAR+1)-01-01
    localparam int TOTAL_DAYS = 365 * (LAST_YEAR - FIRST_YEAR + 1)
        + (LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400)
        - ((FIRST_YEAR - 1) / 4 - (FIRST_YEAR - 1) / 100 + (FIRST_YEAR - 1) / 400);
    localparam int CNT_W = $clog2(TOTAL_DAYS + 1);
    localparam int ACC_W = ((CNT_W > OFF_W) ? CNT_W : OFF_W) + 2;

    localparam int FIRST_MOD4   = FIRST_YEAR % 4;
    localparam int FIRST_MOD100 = FIRST_YEAR % 100;
    localparam int FIRST_MOD400 = FIRST_YEAR % 400;

    localparam logic [CMD_W-1:0] CMD_NORM    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PREV    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EARLIER = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DIFF    = 3'd5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_YEAR_STEP,
        OP_CHECK,
        OP_MONTH_STEP,
        OP_DAY,
        OP_OFFSET,
        OP_FYEAR_STEP,
        OP_FMONTH_STEP,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic year_done;
        logic date_ok;
        logic month_hit;
        logic sel_b;
        logic cmd_move;
        logic cmd_pair;
        logic rng_bad;
        logic fy_more;
        logic fm_more;
    } dp_status_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: hdl/gda_ctrl.sv
module gda_ctrl
    import gda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_op_t     op
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_YEAR   = 9'b000000010,
        S_CHECK  = 9'b000000100,
        S_MONTH  = 9'b000001000,
        S_DAY    = 9'b000010000,
        S_OFFSET = 9'b000100000,
        S_FYEAR  = 9'b001000000,
        S_FMONTH = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   emit_fire;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op         = OP_LOAD;
                    state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (status.year_done)
                    state_next = S_CHECK;
                else
                    op = OP_YEAR_STEP;
            end
            S_CHECK:
            begin
                op         = OP_CHECK;
                state_next = S_MONTH;
            end
            S_MONTH:
            begin
                if (status.month_hit)
                    state_next = S_DAY;
                else
                    op = OP_MONTH_STEP;
            end
            S_DAY:
            begin
                op = OP_DAY;
                if (!status.sel_b && status.cmd_pair)
                    state_next = S_YEAR;
                else if (!status.sel_b && status.cmd_move)
                    state_next = S_OFFSET;
                else
                    state_next = S_EMIT;
            end
            S_OFFSET:
            begin
                op         = OP_OFFSET;
                state_next = S_FYEAR;
            end
            S_FYEAR:
            begin
                if (status.rng_bad)
                    state_next = S_EMIT;
                else if (status.fy_more)
                    op = OP_FYEAR_STEP;
                else
                    state_next = S_FMONTH;
            end
            S_FMONTH:
            begin
                if (status.fm_more)
                    op = OP_FMONTH_STEP;
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/gda_dp.sv
module gda_dp
    import gda_pkg::*;
(
    input  logic                  clk,
    input  dp_op_t                op,
    input  logic [IN_DATA_W-1:0]  in_data,
    output dp_status_t            status,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic [CMD_W-1:0]   cmd_reg;
    logic [YEAR_W-1:0]  ay_reg, by_reg;
    logic [MONTH_W-1:0] am_reg, bm_reg;
    logic [DAY_W-1:0]   ad_reg, bd_reg;
    logic [OFF_W-1:0]   off_reg;
    logic               a_ok_reg;
    logic               sel_b_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic [YEAR_W-1:0]       yy_reg;
    logic [MONTH_W-1:0]      mm_reg;
    logic [1:0]              q4_reg;
    logic [6:0]              q100_reg;
    logic [8:0]              q400_reg;
    logic [CNT_W-1:0]        c1_reg, c2_reg;

    logic [RES_YEAR_W-1:0] ry_reg;
    logic [MONTH_W-1:0]    rm_reg;
    logic [DAY_W-1:0]      rd_reg;
    logic [VALUE_W-1:0]    rv_reg;
    logic                  rvalid_reg;
    logic                  roor_reg;

    logic [YEAR_W-1:0]       tgt_y;
    logic [MONTH_W-1:0]      tgt_m;
    logic [DAY_W-1:0]        tgt_d;
    logic                    leap;
    logic [8:0]              ylen;
    logic [DAY_W-1:0]        mlen_cur, mlen_tgt;
    logic                    yr_in;
    logic signed [ACC_W-1:0] ylen_s, mlen_s, total_s;
    logic signed [ACC_W-1:0] add_base, add_val, add_sum;
    logic signed [ACC_W-1:0] delta;
    logic signed [CNT_W:0]   diff;
    logic [CNT_W:0]          diff_abs;
    logic                    cmd_move, cmd_pair;

    assign tgt_y = sel_b_reg ? by_reg : ay_reg;
    assign tgt_m = sel_b_reg ? bm_reg : am_reg;
    assign tgt_d = sel_b_reg ? bd_reg : ad_reg;

    // leap year tracked by residues of the walking year
    assign leap     = (q4_reg == 2'd0) && ((q100_reg != 7'd0) || (q400_reg == 9'd0));
    assign ylen     = leap ? 9'd366 : 9'd365;
    assign mlen_cur = month_len(mm_reg, leap);
    assign mlen_tgt = month_len(tgt_m, leap);
    assign ylen_s   = ACC_W'(ylen);
    assign mlen_s   = ACC_W'(mlen_cur);
    assign total_s  = ACC_W'(TOTAL_DAYS);

    assign yr_in = (tgt_y >= YEAR_W'(FIRST_YEAR)) && (tgt_y <= YEAR_W'(LAST_YEAR));

    assign cmd_move = (cmd_reg == CMD_NEXT) || (cmd_reg == CMD_PREV) || (cmd_reg == CMD_ADD);
    assign cmd_pair = (cmd_reg == CMD_EARLIER) || (cmd_reg == CMD_DIFF);

    always_comb
    begin
        case (cmd_reg)
            CMD_NEXT: delta = ACC_W'(1);
            CMD_PREV: delta = '1;
            default:  delta = ACC_W'($signed(off_reg));
        endcase
    end

    assign status.year_done = !yr_in || (yy_reg == tgt_y);
    assign status.date_ok   = yr_in && (tgt_d != '0) && (tgt_d <= mlen_tgt);
    assign status.month_hit = (mm_reg == tgt_m);
    assign status.sel_b     = sel_b_reg;
    assign status.cmd_move  = cmd_move;
    assign status.cmd_pair  = cmd_pair;
    assign status.rng_bad   = acc_reg[ACC_W-1] || (acc_reg >= total_s);
    assign status.fy_more   = (yy_reg < YEAR_W'(LAST_YEAR)) && (acc_reg >= ylen_s);
    assign status.fm_more   = (mm_reg < 4'd12) && (acc_reg >= mlen_s);

    // the one shared adder behind every walk step
    always_comb
    begin
        add_base = acc_reg;
        add_val  = '0;
        case (op)
            OP_YEAR_STEP:   add_val = ylen_s;
            OP_MONTH_STEP:  add_val = mlen_s;
            OP_DAY:         add_val = ACC_W'(tgt_d) - ACC_W'(1);
            OP_OFFSET:
            begin
                add_base = ACC_W'(c1_reg);
                add_val  = delta;
            end
            OP_FYEAR_STEP:  add_val = -ylen_s;
            OP_FMONTH_STEP: add_val = -mlen_s;
            default:        add_val = '0;
        endcase
        add_sum = add_base + add_val;
    end

    assign diff     = $signed({1'b0, c1_reg}) - $signed({1'b0, c2_reg});
    assign diff_abs = diff[CNT_W] ? (CNT_W+1)'(0) - diff : diff;

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cmd_reg   <= in_data[2:0];
                ay_reg    <= in_data[14:3];
                am_reg    <= in_data[18:15];
                ad_reg    <= in_data[23:19];
                off_reg   <= in_data[40:24];
                by_reg    <= in_data[52:41];
                bm_reg    <= in_data[56:53];
                bd_reg    <= in_data[61:57];
                a_ok_reg  <= 1'b1;
                sel_b_reg <= 1'b0;
                acc_reg   <= '0;
                yy_reg    <= YEAR_W'(FIRST_YEAR);
                mm_reg    <= 4'd1;
                q4_reg    <= 2'(FIRST_MOD4);
                q100_reg  <= 7'(FIRST_MOD100);
                q400_reg  <= 9'(FIRST_MOD400);
            end
            OP_YEAR_STEP, OP_FYEAR_STEP:
            begin
                acc_reg  <= add_sum;
                yy_reg   <= yy_reg + 1'b1;
                q4_reg   <= q4_reg + 1'b1;
                q100_reg <= (q100_reg == 7'd99) ? 7'd0 : q100_reg + 1'b1;
                q400_reg <= (q400_reg == 9'd399) ? 9'd0 : q400_reg + 1'b1;
            end
            OP_CHECK:
            begin
                if (!status.date_ok)
                begin
                    // bad date becomes the first day of the range
                    acc_reg <= '0;
                    if (sel_b_reg)
                    begin
                        by_reg <= YEAR_W'(FIRST_YEAR);
                        bm_reg <= 4'd1;
                        bd_reg <= 5'd1;
                    end
                    else
                    begin
                        ay_reg   <= YEAR_W'(FIRST_YEAR);
                        am_reg   <= 4'd1;
                        ad_reg   <= 5'd1;
                        a_ok_reg <= 1'b0;
                    end
                end
            end
            OP_MONTH_STEP, OP_FMONTH_STEP:
            begin
                acc_reg <= add_sum;
                mm_reg  <= mm_reg + 1'b1;
            end
            OP_DAY:
            begin
                if (sel_b_reg)
                    c2_reg <= add_sum[CNT_W-1:0];
                else
                    c1_reg <= add_sum[CNT_W-1:0];
                sel_b_reg <= 1'b1;
                acc_reg   <= '0;
                yy_reg    <= YEAR_W'(FIRST_YEAR);
                mm_reg    <= 4'd1;
                q4_reg    <= 2'(FIRST_MOD4);
                q100_reg  <= 7'(FIRST_MOD100);
                q400_reg  <= 9'(FIRST_MOD400);
            end
            OP_OFFSET:
            begin
                acc_reg <= add_sum;
            end
            OP_EMIT:
            begin
                rvalid_reg <= a_ok_reg;
                if (cmd_move)
                begin
                    rv_reg <= '0;
                    if (status.rng_bad)
                    begin
                        ry_reg   <= RES_YEAR_W'(FIRST_YEAR);
                        rm_reg   <= 4'd1;
                        rd_reg   <= 5'd1;
                        roor_reg <= 1'b1;
                    end
                    else
                    begin
                        ry_reg   <= yy_reg[RES_YEAR_W-1:0];
                        rm_reg   <= mm_reg;
                        rd_reg   <= acc_reg[DAY_W-1:0] + 1'b1;
                        roor_reg <= 1'b0;
                    end
                end
                else
                begin
                    ry_reg   <= ay_reg[RES_YEAR_W-1:0];
                    rm_reg   <= am_reg;
                    rd_reg   <= ad_reg;
                    roor_reg <= 1'b0;
                    if (cmd_reg == CMD_EARLIER)
                        rv_reg <= VALUE_W'(diff[CNT_W]);
                    else if (cmd_reg == CMD_DIFF)
                        rv_reg <= diff_abs[VALUE_W-1:0];
                    else
                        rv_reg <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_data = {2'b00, roor_reg, rvalid_reg, rv_reg, rd_reg, rm_reg, ry_reg};

endmodule

// File: hdl/gregorian_date_arithmetic_top.sv
// channel  dir  signals                      beat contents
// s        in   s_tvalid s_tready s_tdata    command, two dates, day offset
// m        out  m_tvalid m_tready m_tdata    result date, value, flags
//
// one beat at a time: a date conversion walks the years, checks the date, walks the months
// and adds the day on the shared walk adder; earlier/difference convert both dates, moves
// add the offset and a reverse walk by year and month back to a date, and s_tready
// returns in the same cycle that m_tvalid rises.
// rst_n clears the controller and the output valid; payload registers are not reset.
// a held result in m_tdata does not block taking the next s beat, it stalls its emit.
module gregorian_date_arithmetic_top
    import gda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command[2:0] date_year[14:3] date_month[18:15] date_day[23:19]
    // day_offset[40:24] other_year[52:41] other_month[56:53] other_day[61:57]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_year[10:0] result_month[14:11] result_day[19:15] result_value[35:20]
    // input_was_valid[36] out_of_range[37]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    dp_op_t     op;
    dp_status_t status;

    gda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .op       (op)
    );

    gda_dp u_dp (
        .clk      (clk),
        .op       (op),
        .in_data  (s_tdata),
        .status   (status),
        .out_data (m_tdata)
    );

endmodule

// File: test/date_result_checker.sv
module date_result_checker
    import gda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    mismatches,
    output int                    outstanding,
    output int                    compared,
    output int                    out_of_range_hits,
    output int                    invalid_dates
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [RES_YEAR_W-1:0] year;
        logic [MONTH_W-1:0]    month;
        logic [DAY_W-1:0]      day;
        logic [VALUE_W-1:0]    value;
        logic                  valid;
        logic                  oor;
    } date_result_t;

    date_result_t expected_q[$];

    int n_mismatch = 0;
    int n_pending  = 0;
    int n_compared = 0;
    int n_oor      = 0;
    int n_invalid  = 0;

    assign mismatches        = n_mismatch;
    assign outstanding       = n_pending;
    assign compared          = n_compared;
    assign out_of_range_hits = n_oor;
    assign invalid_dates     = n_invalid;

    function automatic bit leap_year(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int year_length(int y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int month_length(int y, int m);
        int len;
        case (m)
            2:            len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:  len = 30;
            1, 3, 5, 7, 8, 10, 12: len = 31;
            default:      len = 0;
        endcase
        return len;
    endfunction

    // days from the first supported new year to 1 january of year y
    function automatic int days_to_year(int y);
        int acc;
        acc = 0;
        for (int k = FIRST_YEAR; k < y; k++)
        begin
            acc += year_length(k);
        end
        return acc;
    endfunction

    function automatic bit legal_date(int y, int m, int d);
        if (y < FIRST_YEAR || y > LAST_YEAR)
        begin
            return 1'b0;
        end
        return (d >= 1) && (d <= month_length(y, m));
    endfunction

    function automatic int day_number(int y, int m, int d);
        int acc;
        acc = days_to_year(y);
        for (int k = 1; k < m; k++)
        begin
            acc += month_length(y, k);
        end
        return acc + d - 1;
    endfunction

    function automatic date_result_t predict_result(logic [IN_DATA_W-1:0] beat);
        logic [CMD_W-1:0] cmd;
        int y1, m1, d1, y2, m2, d2, off;
        int c1, c2, n, span, yy, mm;
        logic first_ok;
        date_result_t r;
        cmd = beat[2:0];
        y1  = int'(beat[14:3]);
        m1  = int'(beat[18:15]);
        d1  = int'(beat[23:19]);
        off = int'($signed(beat[40:24]));
        y2  = int'(beat[52:41]);
        m2  = int'(beat[56:53]);
        d2  = int'(beat[61:57]);
        first_ok = legal_date(y1, m1, d1);
        if (!first_ok)
        begin
            y1 = FIRST_YEAR;
            m1 = 1;
            d1 = 1;
        end
        if (!legal_date(y2, m2, d2))
        begin
            y2 = FIRST_YEAR;
            m2 = 1;
            d2 = 1;
        end
        c1   = day_number(y1, m1, d1);
        c2   = day_number(y2, m2, d2);
        span = days_to_year(LAST_YEAR + 1);
        r       = '0;
        r.year  = RES_YEAR_W'(y1);
        r.month = MONTH_W'(m1);
        r.day   = DAY_W'(d1);
        r.valid = first_ok;
        case (cmd)
            CMD_NEXT, CMD_PREV, CMD_ADD:
            begin
                n = c1 + ((cmd == CMD_NEXT) ? 1 : (cmd == CMD_PREV) ? -1 : off);
                if (n < 0 || n >= span)
                begin
                    r.oor   = 1'b1;
                    r.year  = RES_YEAR_W'(FIRST_YEAR);
                    r.month = MONTH_W'(1);
                    r.day   = DAY_W'(1);
                end
                else
                begin
                    yy = FIRST_YEAR;
                    while (yy < LAST_YEAR && n >= year_length(yy))
                    begin
                        n -= year_length(yy);
                        yy++;
                    end
                    mm = 1;
                    while (mm < 12 && n >= month_length(yy, mm))
                    begin
                        n -= month_length(yy, mm);
                        mm++;
                    end
                    r.year  = RES_YEAR_W'(yy);
                    r.month = MONTH_W'(mm);
                    r.day   = DAY_W'(n + 1);
                end
            end
            CMD_EARLIER: r.value = VALUE_W'((c1 < c2) ? 1 : 0);
            CMD_DIFF:    r.value = VALUE_W'((c1 >= c2) ? (c1 - c2) : (c2 - c1));
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        date_result_t want;
        date_result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_q.push_back(predict_result(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                got.year  = m_tdata[10:0];
                got.month = m_tdata[14:11];
                got.day   = m_tdata[19:15];
                got.value = m_tdata[35:20];
                got.valid = m_tdata[36];
                got.oor   = m_tdata[37];
                if (expected_q.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                    begin
                        $display("[%0t] result beat with nothing outstanding: %h", $realtime,
                                 m_tdata);
                    end
                end
                else
                begin
                    want = expected_q.pop_front();
                    n_compared++;
                    if (want.oor)
                    begin
                        n_oor++;
                    end
                    if (!want.valid)
                    begin
                        n_invalid++;
                    end
                    if (got.year !== want.year || got.month !== want.month
                        || got.day !== want.day || got.value !== want.value
                        || got.valid !== want.valid || got.oor !== want.oor)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                        begin
                            $display("[%0t] result %0d wrong", $realtime, n_compared);
                            $display("    want %0d-%0d-%0d value %0d valid %0b oor %0b",
                                     want.year, want.month, want.day, want.value,
                                     want.valid, want.oor);
                            $display("    got  %0d-%0d-%0d value %0d valid %0b oor %0b",
                                     got.year, got.month, got.day, got.value, got.valid,
                                     got.oor);
                        end
                    end
                end
            end
            n_pending = expected_q.size();
        end
    end

endmodule

// File: test/tb_gregorian_date_arithmetic_top.sv
module tb_gregorian_date_arithmetic_top;
    import gda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam int RANDOM_ITEMS = 450;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 500;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int mismatches, outstanding, compared, out_of_range_hits, invalid_dates;

    bit calm = 1'b0;
    int idle_cycles = 0;
    int directed_items = 0;
    int sent_items = 0;
    int cmd_count[8];

    gregorian_date_arithmetic_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    date_result_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .compared          (compared),
        .out_of_range_hits (out_of_range_hits),
        .invalid_dates     (invalid_dates)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 40)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_request(logic [CMD_W-1:0] cmd,
                                                          int y, int m, int d, int off,
                                                          int y2, int m2, int d2);
        return {2'b00, d2[DAY_W-1:0], m2[MONTH_W-1:0], y2[YEAR_W-1:0], off[OFF_W-1:0],
                d[DAY_W-1:0], m[MONTH_W-1:0], y[YEAR_W-1:0], cmd};
    endfunction

    task automatic send_request(logic [IN_DATA_W-1:0] beat);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        cmd_count[beat[2:0]]++;
        sent_items++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // well-formed dates most of the time, edge years favoured, some raw noise
    task automatic pick_date(output int y, output int m, output int d);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            y = $urandom_range(0, 4095);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
        else
        begin
            r = $urandom_range(0, 99);
            y = (r < 10) ? FIRST_YEAR : (r < 20) ? LAST_YEAR : (r < 25) ? 2000
                : $urandom_range(FIRST_YEAR, LAST_YEAR);
            m = $urandom_range(1, 12);
            d = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28);
        end
    endtask

    task automatic send_random();
        logic [CMD_W-1:0] cmd;
        int y, m, d, y2, m2, d2, off, r;
        r   = $urandom_range(0, 99);
        cmd = (r < 4) ? (r[0] ? CMD_SPARE7 : CMD_SPARE6) : CMD_W'($urandom_range(0, 5));
        pick_date(y, m, d);
        pick_date(y2, m2, d2);
        r = $urandom_range(0, 99);
        if (cmd == CMD_ADD && r < 40)
        begin
            off = $urandom_range(0, 800) - 400;
        end
        else if (cmd == CMD_ADD && r < 70)
        begin
            off = $urandom_range(0, 40000) - 20000;
        end
        else
        begin
            off = $urandom_range(0, 17'h1FFFF);
        end
        send_request(pack_request(cmd, y, m, d, off, y2, m2, d2));
    endtask

    // receiver back-pressure
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no beat moved for %0d cycles", STALL_LIMIT);
                $display("tb_gregorian_date_arithmetic_top: errors");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // validation corners
        send_request(pack_request(CMD_NORM, 2000, 2, 29, 0, 1900, 1, 1));
        send_request(pack_request(CMD_NORM, 1900, 2, 29, 0, 1900, 1, 1));
        send_request(pack_request(CMD_NORM, 0, 0, 0, 0, 0, 0, 0));
        send_request(pack_request(CMD_NORM, 4095, 15, 31, -1, 4095, 15, 31));
        send_request(pack_request(CMD_NORM, 1899, 12, 31, 0, 2031, 1, 1));
        send_request(pack_request(CMD_NORM, 2031, 1, 1, 0, 1900, 1, 1));
        send_request(pack_request(CMD_NORM, 2023, 4, 31, 0, 1900, 1, 1));
        // single-day moves across boundaries and off the ends
        send_request(pack_request(CMD_NEXT, 2030, 12, 31, 0, 1900, 1, 1));
        send_request(pack_request(CMD_NEXT, 1999, 12, 31, 0, 1900, 1, 1));
        send_request(pack_request(CMD_NEXT, 2004, 2, 28, 0, 1900, 1, 1));
        send_request(pack_request(CMD_PREV, 1900, 1, 1, 0, 1900, 1, 1));
        send_request(pack_request(CMD_PREV, 2000, 3, 1, 0, 1900, 1, 1));
        // offsets at the field extremes
        send_request(pack_request(CMD_ADD, 1900, 1, 1, 65535, 1900, 1, 1));
        send_request(pack_request(CMD_ADD, 2030, 12, 31, -65536, 1900, 1, 1));
        send_request(pack_request(CMD_ADD, 1900, 1, 1, 47846, 1900, 1, 1));
        send_request(pack_request(CMD_ADD, 2030, 12, 31, -47846, 1900, 1, 1));
        send_request(pack_request(CMD_ADD, 1950, 6, 15, 1000, 1900, 1, 1));
        send_request(pack_request(CMD_ADD, 2020, 1, 1, -20000, 1900, 1, 1));
        send_request(pack_request(CMD_ADD, 1984, 7, 4, 0, 1900, 1, 1));
        // ordering and distance
        send_request(pack_request(CMD_EARLIER, 1900, 1, 1, 0, 2030, 12, 31));
        send_request(pack_request(CMD_EARLIER, 2030, 12, 31, 0, 1900, 1, 1));
        send_request(pack_request(CMD_EARLIER, 2012, 5, 5, 0, 2012, 5, 5));
        send_request(pack_request(CMD_DIFF, 1900, 1, 1, 0, 2030, 12, 31));
        send_request(pack_request(CMD_DIFF, 2030, 12, 31, 0, 1900, 1, 1));
        send_request(pack_request(CMD_DIFF, 1970, 1, 1, 0, 2000, 13, 1));
        // unused codes fall back to normalise
        send_request(pack_request(CMD_SPARE6, 2016, 2, 29, 100, 1900, 1, 1));
        send_request(pack_request(CMD_SPARE7, 2017, 2, 29, -100, 1900, 1, 1));
        directed_items = sent_items;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // a stretch with no idling on either side
            calm = (i >= 150 && i < 230);
            send_random();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests (%0d directed), %0d compared, %0d out of range, %0d bad dates",
                 sent_items, directed_items, compared, out_of_range_hits, invalid_dates);
        $display("per command code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3],
                 cmd_count[4], cmd_count[5], cmd_count[6], cmd_count[7]);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb_gregorian_date_arithmetic_top: clean");
        end
        else
        begin
            $display("tb_gregorian_date_arithmetic_top: errors");
        end
        $finish;
    end

endmodule
